/* rtl/core/rfst_pkg.sv */
// shared types and constants for the rational frame and sample timebase converter
package rfst_pkg;

   // command codes
   localparam logic [1:0] CMD_FRAME_TO_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_SAMPLE_TO_FRAME = 2'd1;
   localparam logic [1:0] CMD_FRAME_TO_TIME   = 2'd2;

   // register indexes
   localparam logic [1:0] REG_FRAME_RATE_NUM = 2'd0;
   localparam logic [1:0] REG_FRAME_RATE_DEN = 2'd1;
   localparam logic [1:0] REG_SAMPLE_RATE    = 2'd2;

   // register reset values
   localparam logic [31:0] RST_FRAME_RATE_NUM = 32'd60;
   localparam logic [31:0] RST_FRAME_RATE_DEN = 32'd1;
   localparam logic [31:0] RST_SAMPLE_RATE    = 32'd48000;

   // step counts minus one of the serial units
   localparam logic [6:0] MUL_STEPS_M1  = 7'd63;
   localparam logic [6:0] DIV_STEPS_M1  = 7'd127;
   localparam logic [6:0] TDEN_STEPS_M1 = 7'd31;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL_RATE,
      ST_SAVE_RATE,
      ST_MUL_INIT,
      ST_MUL_PROD,
      ST_CHECK,
      ST_DIV_Q,
      ST_RES_Q,
      ST_GCD,
      ST_DIV_D,
      ST_RES_D,
      ST_DIV_T,
      ST_RES_T,
      ST_FAIL,
      ST_FIN
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic mul_init_rate;
      logic mul_init_prod;
      logic mul_step;
      logic save_rate;
      logic div_init_q;
      logic div_init_d;
      logic div_init_t;
      logic div_step;
      logic gcd_init;
      logic gcd_step;
      logic res_q;
      logic res_d;
      logic res_t;
      logic res_fail;
      logic out_load;
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       div_zero;
      logic       gcd_done;
   } dp_stat_type;

endpackage

/* rtl/core/rfst_ctrl.sv */
// controller state machine sequencing the serial multiply, divide and gcd steps
module rfst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rfst_pkg::dp_stat_type stat,
   output rfst_pkg::dp_cmd_type  dcmd
);
   import rfst_pkg::*;

   state_type  state_ff, state_in;
   logic [6:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // state, step counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dcmd     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dcmd.load = 1'b1;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            if (stat.cmd == CMD_FRAME_TO_SAMPLE || stat.cmd == CMD_SAMPLE_TO_FRAME) begin
               dcmd.mul_init_rate = 1'b1;
               cnt_in   = MUL_STEPS_M1;
               state_in = ST_MUL_RATE;
            end else if (stat.cmd == CMD_FRAME_TO_TIME) begin
               state_in = ST_MUL_INIT;
            end else begin
               state_in = ST_FAIL;
            end
         end
         ST_MUL_RATE: begin
            dcmd.mul_step = 1'b1;
            if (cnt_ff == '0) state_in = ST_SAVE_RATE;
            else cnt_in = cnt_ff - 7'd1;
         end
         ST_SAVE_RATE: begin
            dcmd.save_rate = 1'b1;
            state_in = ST_MUL_INIT;
         end
         ST_MUL_INIT: begin
            dcmd.mul_init_prod = 1'b1;
            cnt_in   = MUL_STEPS_M1;
            state_in = ST_MUL_PROD;
         end
         ST_MUL_PROD: begin
            dcmd.mul_step = 1'b1;
            if (cnt_ff == '0) state_in = ST_CHECK;
            else cnt_in = cnt_ff - 7'd1;
         end
         ST_CHECK: begin
            if (stat.div_zero) begin
               state_in = ST_FAIL;
            end else begin
               dcmd.div_init_q = 1'b1;
               cnt_in   = DIV_STEPS_M1;
               state_in = ST_DIV_Q;
            end
         end
         ST_DIV_Q: begin
            dcmd.div_step = 1'b1;
            if (cnt_ff == '0) state_in = ST_RES_Q;
            else cnt_in = cnt_ff - 7'd1;
         end
         ST_RES_Q: begin
            if (stat.cmd == CMD_FRAME_TO_TIME) begin
               dcmd.gcd_init = 1'b1;
               state_in = ST_GCD;
            end else begin
               dcmd.res_q = 1'b1;
               state_in = ST_FIN;
            end
         end
         ST_GCD: begin
            if (stat.gcd_done) begin
               dcmd.div_init_d = 1'b1;
               cnt_in   = DIV_STEPS_M1;
               state_in = ST_DIV_D;
            end else begin
               dcmd.gcd_step = 1'b1;
            end
         end
         ST_DIV_D: begin
            dcmd.div_step = 1'b1;
            if (cnt_ff == '0) state_in = ST_RES_D;
            else cnt_in = cnt_ff - 7'd1;
         end
         ST_RES_D: begin
            dcmd.res_d      = 1'b1;
            dcmd.div_init_t = 1'b1;
            cnt_in   = TDEN_STEPS_M1;
            state_in = ST_DIV_T;
         end
         ST_DIV_T: begin
            dcmd.div_step = 1'b1;
            if (cnt_ff == '0) state_in = ST_RES_T;
            else cnt_in = cnt_ff - 7'd1;
         end
         ST_RES_T: begin
            dcmd.res_t = 1'b1;
            state_in = ST_FIN;
         end
         ST_FAIL: begin
            dcmd.res_fail = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dcmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid until the transfer
   always_comb begin
      if (dcmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

endmodule

/* rtl/core/rfst_dp.sv */
// datapath: rate registers, serial multiplier, restoring divider, binary gcd, result
module rfst_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   input  logic [1:0]            req_cmd,
   input  logic signed [63:0]    req_index_in,
   output logic                  rsp_status,
   output logic signed [63:0]    rsp_result_value,
   output logic [31:0]           rsp_time_denominator,
   input  rfst_pkg::dp_cmd_type  dcmd,
   output rfst_pkg::dp_stat_type stat
);
   import rfst_pkg::*;

   logic [31:0]  num_ff, den_ff, rate_ff;
   logic [1:0]   cmd_ff;
   logic         neg_ff;
   logic [63:0]  mag_ff;
   logic [63:0]  drate_ff;
   logic [127:0] acc_ff, acc_in;
   logic [127:0] prod_ff;
   logic [63:0]  aux_ff, aux_in;
   logic [63:0]  rem_ff, rem_in;
   logic [31:0]  ga_ff, ga_in, gb_ff, gb_in;
   logic [4:0]   gk_ff, gk_in;
   logic         res_status_ff;
   logic [63:0]  res_value_ff;
   logic [31:0]  res_tden_ff;
   logic         out_status_ff;
   logic [63:0]  out_value_ff;
   logic [31:0]  out_tden_ff;

   logic [64:0]  mul_sum;
   logic [64:0]  div_trial, div_diff;
   logic         div_ge;
   logic [31:0]  gval;
   logic [127:0] rnd_q;
   logic         rnd_up;

   // true when a magnitude fits signed 64 bits with the given sign
   function automatic logic fits(input logic neg, input logic [127:0] q);
      logic ok;
      ok = (q[127:64] == '0);
      if (neg) ok = ok && (q[63:0] <= 64'h8000_0000_0000_0000);
      else ok = ok && (q[63] == 1'b0);
      return ok;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff  <= RST_FRAME_RATE_NUM;
         den_ff  <= RST_FRAME_RATE_DEN;
         rate_ff <= RST_SAMPLE_RATE;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FRAME_RATE_NUM: num_ff  <= csr_wdata;
            REG_FRAME_RATE_DEN: den_ff  <= csr_wdata;
            REG_SAMPLE_RATE:    rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // serial multiply and divide step logic
   assign mul_sum   = {1'b0, acc_ff[127:64]} + {1'b0, aux_ff};
   assign div_trial = {rem_ff, acc_ff[127]};
   assign div_diff  = div_trial - {1'b0, aux_ff};
   assign div_ge    = (div_trial >= {1'b0, aux_ff});
   assign gval      = ga_ff << gk_ff;

   // rounding of the first quotient
   assign rnd_up = (rem_ff != '0) &&
                   ((cmd_ff == CMD_FRAME_TO_SAMPLE) ? !neg_ff : neg_ff);
   assign rnd_q  = acc_ff + {127'd0, rnd_up};

   // working registers
   always_comb begin
      acc_in = acc_ff;
      aux_in = aux_ff;
      rem_in = rem_ff;
      if (dcmd.mul_init_rate) begin
         acc_in = {96'd0, rate_ff};
         aux_in = {32'd0, den_ff};
      end else if (dcmd.mul_init_prod) begin
         acc_in = {64'd0, mag_ff};
         case (cmd_ff)
            CMD_FRAME_TO_SAMPLE: aux_in = drate_ff;
            CMD_SAMPLE_TO_FRAME: aux_in = {32'd0, num_ff};
            default:             aux_in = {32'd0, den_ff};
         endcase
      end else if (dcmd.mul_step) begin
         if (acc_ff[0]) acc_in = {mul_sum, acc_ff[63:1]};
         else acc_in = {1'b0, acc_ff[127:1]};
      end else if (dcmd.div_init_q) begin
         rem_in = '0;
         aux_in = (cmd_ff == CMD_SAMPLE_TO_FRAME) ? drate_ff : {32'd0, num_ff};
      end else if (dcmd.div_init_d) begin
         acc_in = prod_ff;
         rem_in = '0;
         aux_in = {32'd0, gval};
      end else if (dcmd.div_init_t) begin
         acc_in = {num_ff, 96'd0};
         rem_in = '0;
      end else if (dcmd.div_step) begin
         acc_in = {acc_ff[126:0], div_ge};
         rem_in = div_ge ? div_diff[63:0] : div_trial[63:0];
      end
   end

   // binary gcd of the numerator and the first remainder
   always_comb begin
      ga_in = ga_ff;
      gb_in = gb_ff;
      gk_in = gk_ff;
      if (dcmd.gcd_init) begin
         ga_in = num_ff;
         gb_in = rem_ff[31:0];
         gk_in = '0;
      end else if (dcmd.gcd_step) begin
         if (!ga_ff[0] && !gb_ff[0]) begin
            ga_in = ga_ff >> 1;
            gb_in = gb_ff >> 1;
            gk_in = gk_ff + 5'd1;
         end else if (!ga_ff[0]) begin
            ga_in = ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_in = gb_ff >> 1;
         end else if (ga_ff > gb_ff) begin
            ga_in = gb_ff;
            gb_in = ga_ff - gb_ff;
         end else begin
            gb_in = gb_ff - ga_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      aux_ff <= aux_in;
      rem_ff <= rem_in;
      ga_ff  <= ga_in;
      gb_ff  <= gb_in;
      gk_ff  <= gk_in;
   end

   // item capture and saved intermediates
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= CMD_FRAME_TO_SAMPLE;
      end else if (dcmd.load) begin
         cmd_ff <= req_cmd;
      end
      if (dcmd.load) begin
         neg_ff <= req_index_in[63];
         mag_ff <= req_index_in[63] ? (64'd0 - req_index_in) : req_index_in;
      end
      if (dcmd.save_rate) drate_ff <= acc_ff[63:0];
      if (dcmd.div_init_q) prod_ff <= acc_ff;
   end

   // result assembly
   always_ff @(posedge clock) begin
      if (dcmd.res_q) begin
         res_status_ff <= !fits(neg_ff, rnd_q);
         res_value_ff  <= fits(neg_ff, rnd_q) ?
                          (neg_ff ? (64'd0 - rnd_q[63:0]) : rnd_q[63:0]) : 64'd0;
         res_tden_ff   <= '0;
      end else if (dcmd.res_d) begin
         res_status_ff <= !fits(neg_ff, acc_ff);
         res_value_ff  <= fits(neg_ff, acc_ff) ?
                          (neg_ff ? (64'd0 - acc_ff[63:0]) : acc_ff[63:0]) : 64'd0;
      end else if (dcmd.res_t) begin
         res_tden_ff   <= res_status_ff ? 32'd0 : acc_ff[31:0];
      end else if (dcmd.res_fail) begin
         res_status_ff <= 1'b1;
         res_value_ff  <= '0;
         res_tden_ff   <= '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (dcmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_value_ff  <= res_value_ff;
         out_tden_ff   <= res_tden_ff;
      end
   end

   assign rsp_status           = out_status_ff;
   assign rsp_result_value     = out_value_ff;
   assign rsp_time_denominator = out_tden_ff;

   assign stat.cmd      = cmd_ff;
   assign stat.div_zero = (cmd_ff == CMD_SAMPLE_TO_FRAME) ? (drate_ff == '0) : (num_ff == '0);
   assign stat.gcd_done = (gb_ff == '0);

endmodule

/* rtl/core/rational_frame_sample_timebase_unit.sv */
// top level of the rational frame and audio sample timebase converter
// Converts between video frame indices and audio sample indices for a frame rate
// num/den and a sample rate, or gives a frame's reduced media time. One item is
// worked at a time: a frame-to-sample or sample-to-frame conversion runs two 64-step
// shift-add multiplies and one 128-step restoring divide, a media-time conversion one
// 64-step multiply, two 128-step divides and a 32-step divide, with one binary gcd
// step per cycle between the first and second divide. A reserved command or a zero
// divisor register ends early with a failure result. The bit-serial units are
// shared, and a result waiting on a stalled receiver keeps the next result back
// until it is taken. A new item is taken while the previous result still waits in
// the output register. Rate registers may be written only while the unit is idle.
module rational_frame_sample_timebase_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic signed [63:0] req_index_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_status,
   output logic signed [63:0] rsp_result_value,
   output logic [31:0]        rsp_time_denominator,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import rfst_pkg::*;

   dp_cmd_type  dcmd;
   dp_stat_type stat;

   // sequencer
   rfst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .dcmd      (dcmd)
   );

   // arithmetic
   rfst_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_cmd              (req_cmd),
      .req_index_in         (req_index_in),
      .rsp_status           (rsp_status),
      .rsp_result_value     (rsp_result_value),
      .rsp_time_denominator (rsp_time_denominator),
      .dcmd                 (dcmd),
      .stat                 (stat)
   );

endmodule

/* bench/rfst_conversion_checker.sv */
// checker for the timebase converter: predicts each conversion and compares the results
`timescale 1ns / 1ps

module rfst_conversion_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic signed [63:0] req_index_in,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_status,
   input  logic signed [63:0] rsp_result_value,
   input  logic [31:0]        rsp_time_denominator,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending_count
);
   import rfst_pkg::*;

   typedef struct packed {
      logic        status;
      logic [63:0] value;
      logic [31:0] tden;
   } conversion_t;

   // shadow copy of the rate registers
   logic [31:0] rate_num;
   logic [31:0] rate_den;
   logic [31:0] audio_rate;

   conversion_t expected_results[$];

   initial begin
      fail_count = 0;
   end

   assign pending_count = expected_results.size();

   // exact conversion at 128 bits, with signed 64 bit narrowing
   function automatic conversion_t convert_index(logic [1:0] cmd, logic [63:0] idx);
      logic        neg;
      logic        fits;
      logic        valid_cmd;
      logic [63:0] mag;
      logic [63:0] rate_prod;
      logic [63:0] ga;
      logic [63:0] gb;
      logic [63:0] gt;
      logic [127:0] prod;
      logic [127:0] quo;
      logic [127:0] rem;
      conversion_t res;
      neg = idx[63];
      mag = neg ? (~idx + 64'd1) : idx;
      rate_prod = {32'd0, rate_den} * {32'd0, audio_rate};
      valid_cmd = 1'b0;
      quo = '0;
      res = '0;
      case (cmd)
         CMD_FRAME_TO_SAMPLE: begin
            if (rate_num != 0) begin
               prod = {64'd0, mag} * {64'd0, rate_prod};
               quo = prod / {96'd0, rate_num};
               rem = prod % {96'd0, rate_num};
               // round up for positive frames
               if (!neg && rem != 0)
                  quo = quo + 128'd1;
               valid_cmd = 1'b1;
            end
         end
         CMD_SAMPLE_TO_FRAME: begin
            if (rate_prod != 0) begin
               prod = {64'd0, mag} * {96'd0, rate_num};
               quo = prod / {64'd0, rate_prod};
               rem = prod % {64'd0, rate_prod};
               // floor for negative samples means rounding the magnitude up
               if (neg && rem != 0)
                  quo = quo + 128'd1;
               valid_cmd = 1'b1;
            end
         end
         CMD_FRAME_TO_TIME: begin
            if (rate_num != 0) begin
               prod = {64'd0, mag} * {96'd0, rate_den};
               rem = prod % {96'd0, rate_num};
               ga = {32'd0, rate_num};
               gb = rem[63:0];
               while (gb != 0) begin
                  gt = ga % gb;
                  ga = gb;
                  gb = gt;
               end
               quo = prod / {64'd0, ga};
               res.tden = 32'(ga == 0 ? 64'd0 : {32'd0, rate_num} / ga);
               valid_cmd = 1'b1;
            end
         end
         default: valid_cmd = 1'b0;
      endcase
      fits = valid_cmd && quo[127:64] == 0 &&
             (neg ? quo[63:0] <= 64'h8000_0000_0000_0000
                  : quo[63:0] <  64'h8000_0000_0000_0000);
      if (fits) begin
         res.status = 1'b0;
         res.value  = neg ? (~quo[63:0] + 64'd1) : quo[63:0];
      end else begin
         res = '0;
         res.status = 1'b1;
      end
      return res;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   // register shadow, result comparison and expectation capture
   always @(posedge clock) begin
      conversion_t exp_res;
      if (reset) begin
         rate_num   <= RST_FRAME_RATE_NUM;
         rate_den   <= RST_FRAME_RATE_DEN;
         audio_rate <= RST_SAMPLE_RATE;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_FRAME_RATE_NUM: rate_num   <= csr_wdata;
               REG_FRAME_RATE_DEN: rate_den   <= csr_wdata;
               REG_SAMPLE_RATE:    audio_rate <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_status !== exp_res.status)
                  report_mismatch($sformatf("status %b, expected %b",
                                            rsp_status, exp_res.status));
               if (rsp_result_value !== exp_res.value)
                  report_mismatch($sformatf("result_value %0d, expected %0d",
                                            rsp_result_value, $signed(exp_res.value)));
               if (rsp_time_denominator !== exp_res.tden)
                  report_mismatch($sformatf("time_denominator %0d, expected %0d",
                                            rsp_time_denominator, exp_res.tden));
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(convert_index(req_cmd, req_index_in));
      end
   end

endmodule

/* bench/rational_frame_sample_timebase_unit_test.sv */
// testbench top for the timebase converter: stimulus, register phases and verdict
`timescale 1ns / 1ps

module rational_frame_sample_timebase_unit_test;
   import rfst_pkg::*;

   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam int         CYCLE_LIMIT  = 4000000;
   localparam int         DRAIN_CYCLES = 600;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_cmd;
   logic signed [63:0] req_index_in;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_status;
   logic signed [63:0] rsp_result_value;
   logic [31:0]        rsp_time_denominator;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [31:0]        csr_wdata;
   int                 fail_count;
   int                 pending_count;
   int                 cycle_count;
   int                 burst_left;

   rational_frame_sample_timebase_unit uut (.*);

   rfst_conversion_checker checker_inst (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver stalls, cycling through four ready modes
   always @(posedge clock) begin
      case ((cycle_count / 300) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= cycle_count[0];
      endcase
   end

   function automatic logic [63:0] pick_index();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 6))
         0: v = 64'($signed($urandom_range(0, 10000)) - 5000);
         1: v = {$urandom, $urandom};
         2: v = $urandom_range(0, 1) ? 64'h7fff_ffff_ffff_ffff : 64'h8000_0000_0000_0000;
         3: v = (64'd1 << $urandom_range(0, 62)) + 64'($urandom_range(0, 4)) - 64'd2;
         4: v = {32'd0, $urandom};
         default: v = v >> $urandom_range(1, 63);
      endcase
      if ($urandom_range(0, 3) == 0)
         v = ~v + 64'd1;
      return v;
   endfunction

   function automatic logic [1:0] pick_cmd();
      if ($urandom_range(0, 19) == 0)
         return CMD_RESERVED;
      case ($urandom_range(0, 2))
         0: return CMD_FRAME_TO_SAMPLE;
         1: return CMD_SAMPLE_TO_FRAME;
         default: return CMD_FRAME_TO_TIME;
      endcase
   endfunction

   // one request transfer, then the sender's burst and gap bookkeeping
   task automatic send_request(logic [1:0] cmd, logic [63:0] idx);
      int gap;
      req_cmd      <= cmd;
      req_index_in <= idx;
      req_valid    <= 1'b1;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      if (req_valid)
         req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   task automatic write_rates(logic [31:0] num, logic [31:0] den, logic [31:0] rate);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= REG_FRAME_RATE_NUM;
      csr_wdata <= num;
      @(posedge clock);
      csr_index <= REG_FRAME_RATE_DEN;
      csr_wdata <= den;
      @(posedge clock);
      csr_index <= REG_SAMPLE_RATE;
      csr_wdata <= rate;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(int count);
      repeat (count) send_request(pick_cmd(), pick_index());
   endtask

   // directed corners for every command
   task automatic corner_items();
      send_request(CMD_FRAME_TO_SAMPLE, 64'd0);
      send_request(CMD_FRAME_TO_SAMPLE, 64'd1);
      send_request(CMD_FRAME_TO_SAMPLE, -64'sd1);
      send_request(CMD_FRAME_TO_SAMPLE, 64'h7fff_ffff_ffff_ffff);
      send_request(CMD_SAMPLE_TO_FRAME, 64'h8000_0000_0000_0000);
      send_request(CMD_SAMPLE_TO_FRAME, -64'sd1);
      send_request(CMD_SAMPLE_TO_FRAME, 64'd801);
      send_request(CMD_FRAME_TO_TIME, 64'd0);
      send_request(CMD_FRAME_TO_TIME, 64'd90);
      send_request(CMD_FRAME_TO_TIME, 64'h8000_0000_0000_0000);
      send_request(CMD_RESERVED, 64'd5);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_cmd      = CMD_FRAME_TO_SAMPLE;
      req_index_in = '0;
      rsp_ready    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_index    = REG_FRAME_RATE_NUM;
      csr_wdata    = '0;
      cycle_count  = 0;
      burst_left   = 4;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset rates, then the zero divisor cases
      corner_items();
      write_rates(32'd0, 32'd1, 32'd48000);
      send_request(CMD_FRAME_TO_SAMPLE, 64'd7);
      send_request(CMD_FRAME_TO_TIME, 64'd7);
      write_rates(32'd30000, 32'd0, 32'd48000);
      send_request(CMD_SAMPLE_TO_FRAME, 64'd7);
      send_request(CMD_FRAME_TO_TIME, 64'd7);
      write_rates(32'd30000, 32'd1001, 32'd0);
      send_request(CMD_SAMPLE_TO_FRAME, 64'd7);
      send_request(CMD_FRAME_TO_SAMPLE, 64'd7);

      // random phases over usual and extreme rates
      write_rates(32'd30000, 32'd1001, 32'd48000);
      random_phase(150);
      write_rates(32'd24000, 32'd1001, 32'd44100);
      random_phase(150);
      write_rates(32'd1, 32'd1, 32'd1);
      random_phase(140);
      write_rates(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      corner_items();
      random_phase(140);
      write_rates(32'hffff_ffff, 32'd1, 32'd1);
      random_phase(130);
      write_rates(32'd1, 32'hffff_ffff, 32'd8000);
      random_phase(130);
      write_rates($urandom, $urandom, $urandom);
      random_phase(130);
      write_rates($urandom_range(1, 240000), $urandom_range(1, 1001),
                  $urandom_range(1, 192000));
      random_phase(130);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
rtl/core/rfst_pkg.sv
rtl/core/rfst_ctrl.sv
rtl/core/rfst_dp.sv
rtl/core/rational_frame_sample_timebase_unit.sv
bench/rfst_conversion_checker.sv
bench/rational_frame_sample_timebase_unit_test.sv
